// ----- rtl/cfr_pkg.sv -----
`default_nettype none

package cfr_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam int DATA_W = 40;
  localparam int USER_W = 2;

  // tuser bit positions
  localparam int U_PAYLOAD = 0;
  localparam int U_DONE    = 1;

  typedef enum logic [7:0] {
    PH_SYNC0   = 8'b0000_0001,
    PH_SYNC1   = 8'b0000_0010,
    PH_FUNC    = 8'b0000_0100,
    PH_LENHI   = 8'b0000_1000,
    PH_LENLO   = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRCHI   = 8'b0100_0000,
    PH_CRCLO   = 8'b1000_0000
  } phase_t;

  // CRC-16/MODBUS, one byte, reflected, unrolled over 8 bits
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/crc16_checked_frame_receiver.sv -----
// An accepted item waits in the input register until it is processed; its result (if any)
// is then written to the result register, which drives m_axis_tvalid. A stall holds both.
// Throughput: one item per cycle while the output is not stalled; the byte-wide CRC
// update and phase logic sit between the input register and the result register.
// Reset (rst, synchronous, active high): hunts for the first sync byte, CRC at 0xFFFF,
// held fields and counters cleared, both registers empty.
`default_nettype none

module crc16_checked_frame_receiver
  import cfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,  // [7:0] rx_byte
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [7:0] payload_byte, [8] crc_good, [16:9] function_code,
  // [32:17] payload_length, [39:33] zero
  output logic [DATA_W-1:0]      m_axis_tdata,
  // [0] payload_valid, [1] frame_done
  output logic [USER_W-1:0]      m_axis_tuser
);

  logic        in_valid;
  logic [7:0]  in_byte;

  phase_t      phase, phase_next;
  logic [7:0]  held_function, held_function_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic        first_crc_match, first_crc_match_next;

  logic        proc;
  logic        res_valid;
  logic [7:0]  res_byte;
  logic [USER_W-1:0] res_user;
  logic        res_good;
  logic [15:0] crc_upd;
  logic [15:0] count_inc;
  logic [15:0] len_lo;

  assign proc          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  assign crc_upd   = crc_byte(running_crc, in_byte);
  assign count_inc = payload_count + 16'd1;
  assign len_lo    = {held_length[15:8], in_byte};

  always_comb begin
    phase_next           = phase;
    held_function_next   = held_function;
    held_length_next     = held_length;
    payload_count_next   = payload_count;
    running_crc_next     = running_crc;
    first_crc_match_next = first_crc_match;
    res_valid            = 1'b0;
    res_byte             = 8'h00;
    res_user             = '0;
    res_good             = 1'b0;
    case (phase)
      PH_SYNC0: begin
        if (in_byte == SYNC_FIRST) begin
          running_crc_next = crc_byte(CRC_INIT, in_byte);
          phase_next       = PH_SYNC1;
        end else begin
          running_crc_next = CRC_INIT;
        end
      end
      PH_SYNC1: begin
        if (in_byte == SYNC_SECOND) begin
          running_crc_next = crc_upd;
          phase_next       = PH_FUNC;
        end else begin
          running_crc_next = CRC_INIT;
          phase_next       = PH_SYNC0;
        end
      end
      PH_FUNC: begin
        held_function_next = in_byte;
        running_crc_next   = crc_upd;
        phase_next         = PH_LENHI;
      end
      PH_LENHI: begin
        held_length_next = {in_byte, 8'h00};
        running_crc_next = crc_upd;
        phase_next       = PH_LENLO;
      end
      PH_LENLO: begin
        held_length_next   = len_lo;
        running_crc_next   = crc_upd;
        payload_count_next = '0;
        phase_next         = (len_lo == 16'd0) ? PH_CRCHI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_crc_next   = crc_upd;
        payload_count_next = count_inc;
        res_valid          = 1'b1;
        res_byte           = in_byte;
        res_user[U_PAYLOAD] = 1'b1;
        if (count_inc >= held_length) begin
          phase_next = PH_CRCHI;
        end
      end
      PH_CRCHI: begin
        first_crc_match_next = (in_byte == running_crc[15:8]);
        phase_next           = PH_CRCLO;
      end
      PH_CRCLO: begin
        res_valid         = 1'b1;
        res_user[U_DONE]  = 1'b1;
        res_good          = first_crc_match && (in_byte == running_crc[7:0]);
        running_crc_next  = CRC_INIT;
        phase_next        = PH_SYNC0;
      end
      default: begin
        running_crc_next = CRC_INIT;
        phase_next       = PH_SYNC0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC0;
      held_function   <= '0;
      held_length     <= '0;
      payload_count   <= '0;
      running_crc     <= CRC_INIT;
      first_crc_match <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (proc) begin
        phase           <= phase_next;
        held_function   <= held_function_next;
        held_length     <= held_length_next;
        payload_count   <= payload_count_next;
        running_crc     <= running_crc_next;
        first_crc_match <= first_crc_match_next;
        m_axis_tvalid   <= res_valid;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      m_axis_tdata <= {7'd0, held_length, held_function, res_good, res_byte};
      m_axis_tuser <= res_user;
    end
  end

  // a result is either a payload byte or a frame end, never both
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[U_PAYLOAD] != m_axis_tuser[U_DONE]))
    else $error("result kind not exclusive");

  // payload results never carry a pass flag
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[U_PAYLOAD]) |-> !m_axis_tdata[8])
    else $error("crc_good set on payload item");

  // hunting always starts from a fresh CRC
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SYNC0) |-> (running_crc == CRC_INIT))
    else $error("CRC not reset in hunt");

  // payload phase never runs past the declared length
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_count < held_length))
    else $error("payload count overrun");

  // nothing processed while a result is stalled
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(phase) && m_axis_tvalid))
    else $error("state moved under stalled result");

endmodule

`default_nettype wire

// ----- bench/tb_crc16_checked_frame_receiver.sv -----
`default_nettype none

module tb_crc16_checked_frame_receiver;
  import cfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic        crc_good;
    logic [7:0]  function_code;
    logic [15:0] payload_length;
    logic [6:0]  pad;
  } deframer_out_t;

  typedef enum int {CRC_INTACT, CRC_BAD_HI, CRC_BAD_LO, CRC_BAD_BOTH} crc_fault_t;

  typedef logic [7:0] byte_q_t[$];

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [7:0] payload_byte, [8] crc_good, [16:9] function_code, [32:17] payload_length
  logic [DATA_W-1:0] m_axis_tdata;
  // [0] payload_valid, [1] frame_done
  logic [USER_W-1:0] m_axis_tuser;

  crc16_checked_frame_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // deframer prediction state
  phase_t      deframer_phase = PH_SYNC0;
  logic [7:0]  held_fn = 8'h00;
  logic [15:0] held_len = 16'h0000;
  logic [15:0] payload_seen = 16'h0000;
  logic [15:0] crc_acc = CRC_INIT;
  logic        hi_match = 1'b0;

  deframer_out_t pending_reports[$];

  // sender / receiver idling knobs
  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int ready_run = 0;
  logic ready_level = 1'b1;

  int bytes_accepted = 0;
  int frames_sent = 0;
  int mismatches = 0;
  int payload_reports = 0;
  int good_reports = 0;
  int bad_reports = 0;

  function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void advance_deframer(input logic [7:0] b);
    deframer_out_t r;
    r = '0;
    r.function_code = held_fn;
    r.payload_length = held_len;
    case (deframer_phase)
      PH_SYNC0: begin
        if (b == SYNC_FIRST) begin
          crc_acc = modbus_crc_update(CRC_INIT, b);
          deframer_phase = PH_SYNC1;
        end else begin
          crc_acc = CRC_INIT;
        end
      end
      PH_SYNC1: begin
        if (b == SYNC_SECOND) begin
          crc_acc = modbus_crc_update(crc_acc, b);
          deframer_phase = PH_FUNC;
        end else begin
          crc_acc = CRC_INIT;
          deframer_phase = PH_SYNC0;
        end
      end
      PH_FUNC: begin
        held_fn = b;
        crc_acc = modbus_crc_update(crc_acc, b);
        deframer_phase = PH_LENHI;
      end
      PH_LENHI: begin
        held_len = {b, 8'h00};
        crc_acc = modbus_crc_update(crc_acc, b);
        deframer_phase = PH_LENLO;
      end
      PH_LENLO: begin
        held_len[7:0] = b;
        crc_acc = modbus_crc_update(crc_acc, b);
        payload_seen = 16'h0000;
        deframer_phase = (held_len == 16'h0000) ? PH_CRCHI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_acc = modbus_crc_update(crc_acc, b);
        payload_seen = payload_seen + 16'h0001;
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        pending_reports.push_back(r);
        if (payload_seen >= held_len) begin
          deframer_phase = PH_CRCHI;
        end
      end
      PH_CRCHI: begin
        hi_match = (b == crc_acc[15:8]);
        deframer_phase = PH_CRCLO;
      end
      PH_CRCLO: begin
        r.frame_done = 1'b1;
        r.crc_good = hi_match && (b == crc_acc[7:0]);
        pending_reports.push_back(r);
        crc_acc = CRC_INIT;
        deframer_phase = PH_SYNC0;
      end
      default: begin
        crc_acc = CRC_INIT;
        deframer_phase = PH_SYNC0;
      end
    endcase
  endfunction

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) begin
      q.push_back(8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_axis_tdata <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    advance_deframer(b);
    bytes_accepted++;
    if (gap_max > 0) begin
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, gap_max);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_frame(input logic [7:0] fn, input byte_q_t body,
                            input crc_fault_t fault);
    logic [15:0] crc;
    logic [15:0] len;
    logic [7:0]  hi_flip;
    logic [7:0]  lo_flip;
    byte_q_t     hdr;
    len = 16'(body.size());
    hdr = {SYNC_FIRST, SYNC_SECOND, fn, len[15:8], len[7:0]};
    hi_flip = (fault == CRC_BAD_HI || fault == CRC_BAD_BOTH) ?
              8'($urandom_range(1, 255)) : 8'h00;
    lo_flip = (fault == CRC_BAD_LO || fault == CRC_BAD_BOTH) ?
              8'($urandom_range(1, 255)) : 8'h00;
    crc = CRC_INIT;
    foreach (hdr[i]) begin
      send_byte(hdr[i]);
      crc = modbus_crc_update(crc, hdr[i]);
    end
    foreach (body[i]) begin
      send_byte(body[i]);
      crc = modbus_crc_update(crc, body[i]);
    end
    send_byte(crc[15:8] ^ hi_flip);
    send_byte(crc[7:0] ^ lo_flip);
    frames_sent++;
  endtask

  task automatic wait_all_delivered;
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // wrong second sync byte not rescanned, empty frame, corrupted CRC halves
  task automatic test_sync_and_crc_cases;
    byte_q_t body;
    gap_max = 0;
    stall_pct = 0;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    body = {};
    send_frame(8'h00, body, CRC_INTACT);
    body = {8'h00, 8'hFF};
    send_frame(8'hFF, body, CRC_BAD_LO);
    body = {8'hAA};
    send_frame(8'h5A, body, CRC_BAD_HI);
    wait_all_delivered();
  endtask

  // output held off long enough for the input side to back up
  task automatic test_output_backpressure;
    gap_max = 0;
    stall_pct = 0;
    hold_req = 300;
    send_frame(8'h3C, random_body(40), CRC_INTACT);
    send_frame(8'hC3, random_body(5), CRC_BAD_BOTH);
    wait_all_delivered();
    stall_pct = 40;
    gap_max = 5;
    hold_req = 150;
    send_frame(8'h81, random_body(30), CRC_INTACT);
    wait_all_delivered();
  endtask

  task automatic test_random_frames;
    int         start;
    int         n;
    int         len;
    int         pick;
    logic [7:0] b;
    crc_fault_t fault;
    start = bytes_accepted;
    while (bytes_accepted - start < 1320) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0: begin gap_max = 0; stall_pct = 0; end
          1: begin gap_max = 3; stall_pct = 30; end
          2: begin gap_max = 8; stall_pct = 60; end
          3: begin gap_max = 0; stall_pct = 50; end
          default: begin gap_max = 6; stall_pct = 0; end
        endcase
      end
      if ($urandom_range(0, 99) < 30) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (deframer_phase == PH_SYNC1 && b == SYNC_SECOND) begin
            b = 8'h00;
          end
          send_byte(b);
        end
        if (deframer_phase == PH_SYNC1) begin
          send_byte(8'h3C);
        end
      end
      if ($urandom_range(0, 99) < 10) begin
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_SECOND) begin
          b = SYNC_FIRST;
        end
        send_byte(SYNC_FIRST);
        send_byte(b);
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        len = $urandom_range(0, 16);
      end else if (pick < 97) begin
        len = $urandom_range(17, 64);
      end else begin
        len = $urandom_range(200, 300);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        fault = CRC_INTACT;
      end else if (pick < 80) begin
        fault = CRC_BAD_HI;
      end else if (pick < 90) begin
        fault = CRC_BAD_LO;
      end else begin
        fault = CRC_BAD_BOTH;
      end
      send_frame(8'($urandom_range(0, 255)), random_body(len), fault);
    end
    wait_all_delivered();
  endtask

  always @(posedge clk) begin : rx_side
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        ready_level = ($urandom_range(1, 100) > stall_pct);
        ready_run = $urandom_range(1, 8);
      end
      ready_run--;
      m_axis_tready <= ready_level;
    end
  end

  always @(posedge clk) begin : report_check
    deframer_out_t seen;
    deframer_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.payload_valid  = m_axis_tuser[U_PAYLOAD];
      seen.frame_done     = m_axis_tuser[U_DONE];
      seen.payload_byte   = m_axis_tdata[7:0];
      seen.crc_good       = m_axis_tdata[8];
      seen.function_code  = m_axis_tdata[16:9];
      seen.payload_length = m_axis_tdata[32:17];
      seen.pad            = m_axis_tdata[39:33];
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display({"[%0t] unexpected item: pv=%0b byte=%02h done=%0b good=%0b",
                    " fn=%02h len=%04h"},
                   $realtime, seen.payload_valid, seen.payload_byte, seen.frame_done,
                   seen.crc_good, seen.function_code, seen.payload_length);
        end
      end else begin
        want = pending_reports.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"[%0t] mismatch exp: pv=%0b byte=%02h done=%0b good=%0b",
                      " fn=%02h len=%04h pad=%02h"},
                     $realtime, want.payload_valid, want.payload_byte, want.frame_done,
                     want.crc_good, want.function_code, want.payload_length, want.pad);
            $display({"[%0t]          got: pv=%0b byte=%02h done=%0b good=%0b",
                      " fn=%02h len=%04h pad=%02h"},
                     $realtime, seen.payload_valid, seen.payload_byte, seen.frame_done,
                     seen.crc_good, seen.function_code, seen.payload_length, seen.pad);
          end
        end else if (want.payload_valid) begin
          payload_reports++;
        end else if (want.crc_good) begin
          good_reports++;
        end else begin
          bad_reports++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_sync_and_crc_cases();
    test_output_backpressure();
    test_random_frames();
    $display("Sent %0d bytes in %0d frames plus noise and broken sync pairs.",
             bytes_accepted, frames_sent);
    $display("Checked %0d payload items, %0d good and %0d bad frame ends, under gaps and stalls.",
             payload_reports, good_reports, bad_reports);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/cfr_pkg.sv
rtl/crc16_checked_frame_receiver.sv
bench/tb_crc16_checked_frame_receiver.sv
